[hw/rtl/multi_link_line_assembler_defines.svh]
// ----------------------------------------------------------------------------
// multi_link_line_assembler_defines
// Assertion macros shared by the line assembler RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_LINK_LINE_ASSEMBLER_DEFINES_SVH
`define MULTI_LINK_LINE_ASSEMBLER_DEFINES_SVH

// check cons in the same cycle as ante
`define MLLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define MLLA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// check expr at every edge out of reset
`define MLLA_ASSERT_ALW(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

[hw/rtl/mlla_pkg.sv]
// ----------------------------------------------------------------------------
// mlla_pkg
// Sizes, character codes and shared types of the line assembler.
// ----------------------------------------------------------------------------
package mlla_pkg;

  localparam int LINK_W      = 1;
  localparam int BYTE_W      = 8;
  localparam int BUF_LEN     = 64;
  localparam int NUM_LINKS   = 2;
  localparam int LINK_SLOTS  = 2 ** LINK_W;
  localparam int CNT_W       = $clog2(BUF_LEN);
  localparam int STORE_DEPTH = NUM_LINKS * BUF_LEN;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              fire;
    logic [LINK_W-1:0] link;
    logic              last;
  } issue_t;

endpackage

[hw/rtl/mlla_if.sv]
// ----------------------------------------------------------------------------
// mlla_if
// Request channels of the line assembler: received bytes and line characters.
// ----------------------------------------------------------------------------
interface mlla_in_if;
  import mlla_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINK_W-1:0] link_id;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, link_id, rx_byte, input ready);
  modport sink (input valid, link_id, rx_byte, output ready);
endinterface

interface mlla_out_if;
  import mlla_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINK_W-1:0] out_link;
  logic [BYTE_W-1:0] out_char;
  logic              end_of_line;

  modport source (output valid, out_link, out_char, end_of_line, input ready);
  modport sink (input valid, out_link, out_char, end_of_line, output ready);
endinterface

[hw/rtl/mlla_out_stage.sv]
// ----------------------------------------------------------------------------
// mlla_out_stage
// Tracks store read data in flight and registers it into the output request.
// ----------------------------------------------------------------------------
`include "multi_link_line_assembler_defines.svh"

module mlla_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  mlla_pkg::issue_t              iss,
  input  logic [mlla_pkg::BYTE_W-1:0]   rd_char,
  output logic                          room,
  mlla_out_if.source                    lines
);
  import mlla_pkg::*;

  logic              pend;
  logic [LINK_W-1:0] pend_link;
  logic              pend_last;
  logic              ov;
  logic [LINK_W-1:0] olink;
  logic [BYTE_W-1:0] ochar;
  logic              oeol;
  logic              moving;

  assign moving = pend && (!ov || lines.ready);
  assign room   = !pend || moving;

  assign lines.valid       = ov;
  assign lines.out_link    = olink;
  assign lines.out_char    = ochar;
  assign lines.end_of_line = oeol;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      ov   <= 1'b0;
    end else begin
      if (iss.fire) begin
        pend <= 1'b1;
      end else if (moving) begin
        pend <= 1'b0;
      end
      if (moving) begin
        ov <= 1'b1;
      end else if (lines.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss.fire) begin
      pend_link <= iss.link;
      pend_last <= iss.last;
    end
    if (moving) begin
      olink <= pend_link;
      ochar <= rd_char;
      oeol  <= pend_last;
    end
  end

  `MLLA_ASSERT_IMP(a_no_overrun, iss.fire, !pend || moving, "read issued over held data")
  `MLLA_ASSERT_NXT(a_pend_hold, pend && !moving, pend && $stable(pend_last), "held data lost")

endmodule

[hw/rtl/multi_link_line_assembler.sv]
// An ordinary byte on a valid link is stored in the cycle it is accepted while its buffer has room.
// A terminator on a line of n bytes holds off input for n store reads, one per byte;
// read data is held pending, then registered into the output; one per cycle unless stalled.
// Output stalls stretch the emission; the single store read port sets the pace.
// Reset clears the per-link counts and the request handshakes; store contents stay undefined.
// ----------------------------------------------------------------------------
// multi_link_line_assembler
// Per-link line buffers in one store; CR or LF emits the buffered line.
// ----------------------------------------------------------------------------
`include "multi_link_line_assembler_defines.svh"

module multi_link_line_assembler (
  input  logic      clk,
  input  logic      rst,
  mlla_in_if.sink   bytes,
  mlla_out_if.source lines
);
  import mlla_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  line_count [LINK_SLOTS];
  logic [BYTE_W-1:0] line_store [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_char;
  logic [LINK_W-1:0] em_link;
  logic [CNT_W-1:0]  em_len;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  cnt_cur;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              accept;
  logic              link_ok;
  logic              is_term;
  logic              do_append;
  logic              do_start;
  logic              room;
  issue_t            iss;

  assign accept  = bytes.valid && bytes.ready;
  assign link_ok = int'(bytes.link_id) < NUM_LINKS;
  assign is_term = (bytes.rx_byte == CHAR_CR) || (bytes.rx_byte == CHAR_LF);
  assign cnt_cur = line_count[bytes.link_id];

  assign do_append = accept && link_ok && !is_term && (cnt_cur < CNT_W'(BUF_LEN - 1));
  assign do_start  = accept && link_ok && is_term && (cnt_cur != '0);

  assign wr_addr = ADDR_W'(bytes.link_id) * ADDR_W'(BUF_LEN) + ADDR_W'(cnt_cur);
  assign rd_addr = ADDR_W'(em_link) * ADDR_W'(BUF_LEN) + ADDR_W'(rd_idx);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_start) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (iss.fire && iss.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    bytes.ready = 1'b0;
    iss.fire    = 1'b0;
    iss.link    = em_link;
    iss.last    = (rd_idx == em_len - 1'b1);
    case (state)
      ST_IDLE: bytes.ready = 1'b1;
      ST_EMIT: iss.fire = room;
      default: bytes.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int k = 0; k < LINK_SLOTS; k++) begin
        line_count[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (do_append) begin
        line_count[bytes.link_id] <= cnt_cur + 1'b1;
      end else if (do_start) begin
        line_count[bytes.link_id] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      em_link <= bytes.link_id;
      em_len  <= cnt_cur;
      rd_idx  <= '0;
    end else if (iss.fire) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      line_store[wr_addr] <= bytes.rx_byte;
    end
    if (iss.fire) begin
      rd_char <= line_store[rd_addr];
    end
  end

  mlla_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .iss     (iss),
    .rd_char (rd_char),
    .room    (room),
    .lines   (lines)
  );

  `MLLA_ASSERT_IMP(a_len_nonzero, iss.fire, em_len != '0, "emission of an empty line")
  `MLLA_ASSERT_ALW(a_count_bound, cnt_cur <= CNT_W'(BUF_LEN - 1), "line count overflow")
  `MLLA_ASSERT_NXT(a_emit_done, iss.fire && iss.last, state == ST_IDLE, "emission did not end")

endmodule
